// ----- rtl/core/laser_scan_to_map_points_defines.svh -----
// assertion macros for the laser scan projection block
`ifndef LASER_SCAN_TO_MAP_POINTS_DEFINES_SVH
`define LASER_SCAN_TO_MAP_POINTS_DEFINES_SVH

// checked only while out of reset
`define LSMP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("lsmp port check failed");

// checked on every edge, reset included
`define LSMP_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lsmp reset check failed");

`endif

// ----- rtl/core/lsmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lsmp_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int ANGLE_BITS_MAX = 24;
    localparam int PHASE_W        = 32;
    localparam int CORDIC_ITERS   = 24;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_MOUNT_X       = 3'd0,
        REG_MOUNT_Y       = 3'd1,
        REG_MOUNT_HEADING = 3'd2,
        REG_START_ANGLE   = 3'd3,
        REG_ANGLE_STEP    = 3'd4,
        REG_MIN_RANGE     = 3'd5,
        REG_MAX_RANGE     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] mount_x;
        logic [31:0] mount_y;
        logic [15:0] mount_heading;
        logic [15:0] start_angle;
        logic [15:0] angle_step;
        logic [23:0] min_range;
        logic [23:0] max_range;
    } cfg_t;

    // one queued beam, angles already scaled to a full 32-bit turn
    typedef struct packed {
        logic        first;
        logic        valid;
        logic [23:0] range;
        logic [31:0] beam_phase;
        logic [31:0] robot_x;
        logic [31:0] robot_y;
        logic [31:0] robot_phase;
    } beam_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] phase;
    } cordic_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] cos_q30;
        logic [31:0] sin_q30;
    } cordic_rsp_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lsmp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsmp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lsmp_pkg::beam_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output lsmp_pkg::beam_entry_t head,
    output logic                  empty
);
    import lsmp_pkg::*;

    beam_entry_t head_reg;
    beam_entry_t second_reg;
    logic        head_vld_reg;
    logic        second_vld_reg;

    assign head  = head_reg;
    assign empty = !head_vld_reg;
    assign full  = second_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg   <= 1'b0;
            second_vld_reg <= 1'b0;
        end else begin
            case ({push, pop})
                2'b10: begin
                    if (!head_vld_reg) begin
                        head_reg     <= push_entry;
                        head_vld_reg <= 1'b1;
                    end else begin
                        second_reg     <= push_entry;
                        second_vld_reg <= 1'b1;
                    end
                end
                2'b01: begin
                    if (second_vld_reg) begin
                        head_reg       <= second_reg;
                        second_vld_reg <= 1'b0;
                    end else begin
                        head_vld_reg <= 1'b0;
                    end
                end
                2'b11: begin
                    if (second_vld_reg) begin
                        head_reg   <= second_reg;
                        second_reg <= push_entry;
                    end else begin
                        head_reg <= push_entry;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lsmp_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsmp_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lsmp_pkg::cordic_req_t req,
    output lsmp_pkg::cordic_rsp_t rsp
);
    import lsmp_pkg::*;

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [4:0]         iter_reg;
    logic [1:0]         quad_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [31:0]        cos_reg;
    logic [31:0]        sin_reg;

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] neg_x;
    logic signed [33:0] neg_y;
    logic signed [32:0] atan_val;

    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;
    assign neg_x    = -x_reg;
    assign neg_y    = -y_reg;
    assign atan_val = $signed({1'b0, cordic_atan(iter_reg)});

    assign rsp.done    = done_reg;
    assign rsp.cos_q30 = cos_reg;
    assign rsp.sin_q30 = sin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && (iter_reg == 5'(CORDIC_ITERS));
            if (req.start) begin
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                z_reg    <= $signed({3'b000, req.phase[29:0]});
                quad_reg <= req.phase[31:30];
                iter_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (iter_reg == 5'(CORDIC_ITERS)) begin
                    // fold the quadrant back in
                    case (quad_reg)
                        2'd0: begin
                            cos_reg <= 32'(x_reg);
                            sin_reg <= 32'(y_reg);
                        end
                        2'd1: begin
                            cos_reg <= 32'(neg_y);
                            sin_reg <= 32'(x_reg);
                        end
                        2'd2: begin
                            cos_reg <= 32'(neg_x);
                            sin_reg <= 32'(neg_y);
                        end
                        default: begin
                            cos_reg <= 32'(y_reg);
                            sin_reg <= 32'(neg_x);
                        end
                    endcase
                    busy_reg <= 1'b0;
                end else begin
                    if (!z_reg[32]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_val;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_val;
                    end
                    iter_reg <= iter_reg + 5'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lsmp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsmp_front #(
    parameter int ANGLE_BITS = lsmp_pkg::ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [103:0]          s_tdata,
    input  logic [1:0]            s_tuser,
    input  lsmp_pkg::cfg_t        cfg,
    input  logic                  queue_full,
    output logic                  push,
    output lsmp_pkg::beam_entry_t entry
);
    import lsmp_pkg::*;

    localparam int PAD = PHASE_W - ANGLE_BITS;

    logic [23:0]               beam_range;
    logic [15:0]               robot_heading;
    logic                      range_finite;
    logic                      first_beam;
    logic                      accept;

    logic [ANGLE_BITS-1:0]     sensor_heading_reg;
    logic [15:0]               beam_index_reg;
    logic [ANGLE_BITS-1:0]     robot_ang;
    logic [ANGLE_BITS-1:0]     heading_next;
    logic [15:0]               index_cur;
    logic [ANGLE_BITS_MAX-1:0] step_ext;
    logic [ANGLE_BITS_MAX-1:0] step_prod;
    logic [ANGLE_BITS-1:0]     beam_ang;

    assign beam_range    = s_tdata[23:0];
    assign robot_heading = s_tdata[103:88];
    assign range_finite  = s_tuser[0];
    assign first_beam    = s_tuser[1];

    assign robot_ang    = ANGLE_BITS'(robot_heading);
    assign heading_next = first_beam ? robot_ang + ANGLE_BITS'(cfg.mount_heading)
                                     : sensor_heading_reg;
    assign index_cur    = first_beam ? 16'd0 : beam_index_reg;
    assign step_ext     = ANGLE_BITS_MAX'($signed(cfg.angle_step));
    assign step_prod    = ANGLE_BITS_MAX'(index_cur) * step_ext;
    assign beam_ang     = heading_next + ANGLE_BITS'(cfg.start_angle)
                        + ANGLE_BITS'(step_prod);

    assign entry.first       = first_beam;
    assign entry.valid       = range_finite && (beam_range >= cfg.min_range)
                               && (beam_range <= cfg.max_range);
    assign entry.range       = beam_range;
    assign entry.beam_phase  = PHASE_W'(beam_ang) << PAD;
    assign entry.robot_x     = s_tdata[55:24];
    assign entry.robot_y     = s_tdata[87:56];
    assign entry.robot_phase = PHASE_W'(robot_ang) << PAD;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    // rejected beams that start no scan never reach the back end
    assign push     = accept && (first_beam || entry.valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_heading_reg <= '0;
            beam_index_reg     <= '0;
        end else if (accept) begin
            beam_index_reg <= index_cur + 16'd1;
            if (first_beam) begin
                sensor_heading_reg <= heading_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lsmp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsmp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lsmp_pkg::cfg_t        cfg,
    input  logic                  queue_empty,
    input  lsmp_pkg::beam_entry_t queue_head,
    output logic                  queue_pop,
    output lsmp_pkg::cordic_req_t cordic_req,
    input  lsmp_pkg::cordic_rsp_t cordic_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata
);
    import lsmp_pkg::*;

    localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POSE_START,
        ST_POSE_WAIT,
        ST_POSE_M0,
        ST_POSE_M1,
        ST_POSE_M2,
        ST_POSE_M3,
        ST_POSE_M4,
        ST_POSE_M5,
        ST_BEAM_START,
        ST_BEAM_WAIT,
        ST_BEAM_M0,
        ST_BEAM_M1,
        ST_BEAM_M2,
        ST_BEAM_M3,
        ST_OUT
    } state_t;

    state_t             state_reg;
    beam_entry_t        cur_reg;
    logic [31:0]        sensor_x_reg;
    logic [31:0]        sensor_y_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic               out_valid_reg;
    logic [31:0]        out_x_reg;
    logic [31:0]        out_y_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod_ext;
    logic signed [65:0] acc_shift;
    logic [31:0]        sum_base;
    logic [36:0]        sum_full;
    logic [31:0]        sum_sat;

    function automatic logic [31:0] sat32(input logic [36:0] v);
        logic [31:0] r;
        if ((&v[36:31]) || !(|v[36:31])) begin
            r = v[31:0];
        end else begin
            r = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    assign queue_pop = (state_reg == ST_IDLE) && !queue_empty;

    assign cordic_req.start = (state_reg == ST_POSE_START) || (state_reg == ST_BEAM_START);
    assign cordic_req.phase = (state_reg == ST_POSE_START) ? cur_reg.robot_phase
                                                           : cur_reg.beam_phase;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POSE_M0: begin
                mul_a = $signed(cordic_rsp.cos_q30);
                mul_b = $signed(cfg.mount_x);
            end
            ST_POSE_M1: begin
                mul_a = $signed(cordic_rsp.sin_q30);
                mul_b = $signed(cfg.mount_y);
            end
            ST_POSE_M2: begin
                mul_a = $signed(cordic_rsp.sin_q30);
                mul_b = $signed(cfg.mount_x);
            end
            ST_POSE_M3: begin
                mul_a = $signed(cordic_rsp.cos_q30);
                mul_b = $signed(cfg.mount_y);
            end
            ST_BEAM_M0: begin
                mul_a = $signed({8'd0, cur_reg.range});
                mul_b = $signed(cordic_rsp.cos_q30);
            end
            ST_BEAM_M1: begin
                mul_a = $signed({8'd0, cur_reg.range});
                mul_b = $signed(cordic_rsp.sin_q30);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_POSE_M3: sum_base = cur_reg.robot_x;
            ST_POSE_M5: sum_base = cur_reg.robot_y;
            ST_BEAM_M2: sum_base = sensor_x_reg;
            default:    sum_base = sensor_y_reg;
        endcase
    end

    // q46 to q16 with the rounding half already in the accumulator
    assign prod_ext  = {{2{prod_reg[63]}}, prod_reg};
    assign acc_shift = acc_reg >>> 30;
    assign sum_full  = {{5{sum_base[31]}}, sum_base} + acc_shift[36:0];
    assign sum_sat   = sat32(sum_full);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sensor_x_reg  <= '0;
            sensor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            prod_reg <= mul_a * mul_b;
            if (out_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!queue_empty) begin
                        cur_reg   <= queue_head;
                        state_reg <= queue_head.first ? ST_POSE_START : ST_BEAM_START;
                    end
                end
                ST_POSE_START: state_reg <= ST_POSE_WAIT;
                ST_POSE_WAIT: begin
                    if (cordic_rsp.done) begin
                        state_reg <= ST_POSE_M0;
                    end
                end
                ST_POSE_M0: state_reg <= ST_POSE_M1;
                ST_POSE_M1: begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_POSE_M2;
                end
                ST_POSE_M2: begin
                    acc_reg   <= acc_reg - prod_ext + HALF_Q30;
                    state_reg <= ST_POSE_M3;
                end
                ST_POSE_M3: begin
                    sensor_x_reg <= sum_sat;
                    acc_reg      <= prod_ext;
                    state_reg    <= ST_POSE_M4;
                end
                ST_POSE_M4: begin
                    acc_reg   <= acc_reg + prod_ext + HALF_Q30;
                    state_reg <= ST_POSE_M5;
                end
                ST_POSE_M5: begin
                    sensor_y_reg <= sum_sat;
                    state_reg    <= cur_reg.valid ? ST_BEAM_START : ST_IDLE;
                end
                ST_BEAM_START: state_reg <= ST_BEAM_WAIT;
                ST_BEAM_WAIT: begin
                    if (cordic_rsp.done) begin
                        state_reg <= ST_BEAM_M0;
                    end
                end
                ST_BEAM_M0: state_reg <= ST_BEAM_M1;
                ST_BEAM_M1: begin
                    acc_reg   <= prod_ext + HALF_Q30;
                    state_reg <= ST_BEAM_M2;
                end
                ST_BEAM_M2: begin
                    px_reg    <= sum_sat;
                    acc_reg   <= prod_ext + HALF_Q30;
                    state_reg <= ST_BEAM_M3;
                end
                ST_BEAM_M3: begin
                    py_reg    <= sum_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= px_reg;
                        out_y_reg     <= py_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/laser_scan_to_map_points.sv -----
// Laser scan to map points.
// Input stream: one laser beam per beat. s_tdata carries the range, the robot pose
// and heading; s_tuser carries the finite flag and the first-beam flag. A first beam
// latches a new sensor pose from the robot pose and the mounting registers.
// Output stream: one beat per accepted beam that is finite and inside the range
// limits, carrying the map point (x, y) in signed Q16.16. Other beams give nothing.
// A first beam takes longer than an ordinary beam, as it also rotates the mounting
// pose before the beam rotation.
// The back end pops a new beam only once done with the last, and both the pose and
// the beam rotation use the 24-step iterative CORDIC. Rejected ordinary beams pass
// the input while the queue has room and never occupy the back end.
// A two-beat queue parts the input side from the compute side; s_tready drops
// only when that queue is full. A stalled receiver holds the output register and
// the queue fills behind it.
// Reset (aresetn low, synchronous) clears the sensor pose, beam index, queue and
// output valid and loads the register defaults. Configuration writes take effect
// at the next edge. The user must make them while the block is idle; it does not check.
`timescale 1ns / 1ps
`default_nettype none

module laser_scan_to_map_points #(
    parameter int ANGLE_BITS = lsmp_pkg::ANGLE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // beam_range [23:0], robot_x [55:24], robot_y [87:56], robot_heading [103:88]
    input  logic [103:0] s_tdata,
    // range_finite [0], first_beam [1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x [31:0], point_y [63:32]
    output logic [63:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wr_data
);
    import lsmp_pkg::*;

    cfg_t        cfg_reg;
    logic        queue_full;
    logic        queue_empty;
    logic        queue_push;
    logic        queue_pop;
    beam_entry_t push_entry;
    beam_entry_t head_entry;
    cordic_req_t cordic_req;
    cordic_rsp_t cordic_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mount_x       <= '0;
            cfg_reg.mount_y       <= '0;
            cfg_reg.mount_heading <= '0;
            cfg_reg.start_angle   <= '0;
            cfg_reg.angle_step    <= '0;
            cfg_reg.min_range     <= '0;
            cfg_reg.max_range     <= 24'hFF_FFFF;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_MOUNT_X:       cfg_reg.mount_x       <= cfg_wr_data;
                REG_MOUNT_Y:       cfg_reg.mount_y       <= cfg_wr_data;
                REG_MOUNT_HEADING: cfg_reg.mount_heading <= cfg_wr_data[15:0];
                REG_START_ANGLE:   cfg_reg.start_angle   <= cfg_wr_data[15:0];
                REG_ANGLE_STEP:    cfg_reg.angle_step    <= cfg_wr_data[15:0];
                REG_MIN_RANGE:     cfg_reg.min_range     <= cfg_wr_data[23:0];
                REG_MAX_RANGE:     cfg_reg.max_range     <= cfg_wr_data[23:0];
                default: begin
                end
            endcase
        end
    end

    lsmp_front #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (queue_push),
        .entry      (push_entry)
    );

    lsmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (queue_push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (queue_pop),
        .head       (head_entry),
        .empty      (queue_empty)
    );

    lsmp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .rsp     (cordic_rsp)
    );

    lsmp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .queue_head  (head_entry),
        .queue_pop   (queue_pop),
        .cordic_req  (cordic_req),
        .cordic_rsp  (cordic_rsp),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lsmp_port_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "laser_scan_to_map_points_defines.svh"

module lsmp_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // nothing is left pending on the output after reset
    `LSMP_ASSERT_NR(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

    // the input queue is not full right after reset, so s_tready is high
    `LSMP_ASSERT_NR(a_reset_ready, aclk, !aresetn |=> s_tready)

    // a stalled output beat holds
    `LSMP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a point needs the full compute path, so none shows right after reset
    `LSMP_ASSERT(a_no_early_point, aclk, aresetn, $rose(m_tvalid) |-> $past(aresetn) && $past(aresetn, 2) && $past(aresetn, 3))

endmodule

bind laser_scan_to_map_points lsmp_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
